FILE: design/setc_pkg.sv
package setc_pkg;

  // Field widths
  localparam int SAMPLE_W = 8;
  localparam int CFG_W    = 13;
  localparam int INDEX_W  = 12;
  localparam int THR_W    = 9;   // level / 20 tops out at 409
  localparam int SUM_W    = 12;  // 1+2+3+2+1 = 9 weights of an 8-bit sample

  // Default longest capture
  localparam int MAX_CAPTURE_DEF = 4096;

  // Register reset values
  localparam logic             SLOPE_RESET  = 1'b1;
  localparam logic [THR_W-1:0] THR_RESET    = 9'd128;   // 2560 / 20
  localparam logic [CFG_W-1:0] LENGTH_RESET = 13'd64;

  // x / 20 = ((x >> 2) * 52429) >> 18, exact for 11-bit (x >> 2)
  localparam int               LEVEL_PRE_SHIFT = 2;
  localparam int               LEVEL_Q_W       = CFG_W - LEVEL_PRE_SHIFT;
  localparam logic [15:0]      LEVEL_RECIP     = 16'd52429;
  localparam int               LEVEL_SHIFT     = 18;

  // s / 9 = (s * 7282) >> 16, exact for s below 2^12
  localparam logic [12:0]      SMOOTH_RECIP = 13'd7282;
  localparam int               SMOOTH_SHIFT = 16;

  // Queue between front and back
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_SLOPE  = 2'd0,
    REG_LEVEL  = 2'd1,
    REG_LENGTH = 2'd2
  } cfg_reg_t;

  // One captured pair
  typedef struct packed {
    logic               last;
    logic [INDEX_W-1:0] index;
    logic [SAMPLE_W-1:0] b;
    logic [SAMPLE_W-1:0] a;
  } item_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

FILE: design/setc_front.sv
module setc_front #(
  parameter int MAX_CAPTURE = setc_pkg::MAX_CAPTURE_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_wen,
  input  logic [1:0]                      cfg_addr,
  input  logic [setc_pkg::CFG_W-1:0]      cfg_wdata,
  // sample input
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [setc_pkg::SAMPLE_W-1:0]   in_a,
  input  logic [setc_pkg::SAMPLE_W-1:0]   in_b,
  // queue write side
  input  setc_pkg::queue_status_t         q_status,
  output logic                            q_push,
  output setc_pkg::item_t                 q_item
);

  localparam int CNT_W  = $clog2(MAX_CAPTURE);
  localparam int LEN_W0 = $clog2(MAX_CAPTURE + 1);
  localparam int LEN_W  = (LEN_W0 > setc_pkg::CFG_W) ? LEN_W0 : setc_pkg::CFG_W;
  localparam int SW     = setc_pkg::SAMPLE_W;
  localparam int TW     = setc_pkg::THR_W;
  localparam int QW     = setc_pkg::LEVEL_Q_W;

  // configuration registers
  logic                       slope;
  logic [TW-1:0]              thr;
  logic [setc_pkg::CFG_W-1:0] cfg_len;

  // trigger and capture state
  logic [SW-1:0]    hist [4];
  logic [SW-1:0]    prev_sm;
  logic             capturing;
  logic [CNT_W-1:0] count;

  logic [QW-1:0]                 level_q;
  logic [QW+15:0]                level_prod;
  logic [setc_pkg::SUM_W-1:0]    sum;
  logic [setc_pkg::SUM_W+12:0]   sm_prod;
  logic [SW-1:0]                 smoothed;
  logic [TW-1:0]                 h0_ext;
  logic [TW-1:0]                 a_ext;
  logic                          fire;
  logic                          emit;
  logic                          accept;
  logic [LEN_W-1:0]              len_raw;
  logic [LEN_W-1:0]              len_eff;
  logic [LEN_W-1:0]              count_plus;
  logic                          last;
  logic [31:0]                   count_wide;

  // threshold computed on the write, level / 20 by reciprocal
  assign level_q    = cfg_wdata[setc_pkg::CFG_W-1:setc_pkg::LEVEL_PRE_SHIFT];
  assign level_prod = (QW+16)'(level_q) * (QW+16)'(setc_pkg::LEVEL_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      slope   <= setc_pkg::SLOPE_RESET;
      thr     <= setc_pkg::THR_RESET;
      cfg_len <= setc_pkg::LENGTH_RESET;
    end else if (cfg_wen) begin
      unique case (setc_pkg::cfg_reg_t'(cfg_addr))
        setc_pkg::REG_SLOPE:  slope   <= cfg_wdata[0];
        setc_pkg::REG_LEVEL:  thr     <= level_prod[setc_pkg::LEVEL_SHIFT +: TW];
        setc_pkg::REG_LENGTH: cfg_len <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // weighted sum 1,2,3,2,1 and divide by 9
  assign sum = setc_pkg::SUM_W'(in_a)
             + setc_pkg::SUM_W'({hist[0], 1'b0})
             + setc_pkg::SUM_W'({hist[1], 1'b0}) + setc_pkg::SUM_W'(hist[1])
             + setc_pkg::SUM_W'({hist[2], 1'b0})
             + setc_pkg::SUM_W'(hist[3]);
  assign sm_prod  = (setc_pkg::SUM_W+13)'(sum) * (setc_pkg::SUM_W+13)'(setc_pkg::SMOOTH_RECIP);
  assign smoothed = sm_prod[setc_pkg::SMOOTH_SHIFT +: SW];

  // edge detect against the threshold
  assign h0_ext = TW'(hist[0]);
  assign a_ext  = TW'(in_a);

  always_comb begin
    if (slope) begin
      fire = (h0_ext < thr) && (a_ext >= thr) && (smoothed > prev_sm);
    end else begin
      fire = (h0_ext > thr) && (a_ext <= thr) && (smoothed < prev_sm);
    end
  end

  // capture length clamped to 1..MAX_CAPTURE
  assign len_raw = LEN_W'(cfg_len);

  always_comb begin
    priority if (len_raw == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_raw > LEN_W'(MAX_CAPTURE)) begin
      len_eff = LEN_W'(MAX_CAPTURE);
    end else begin
      len_eff = len_raw;
    end
  end

  assign count_plus = LEN_W'(count) + LEN_W'(1);
  assign last       = count_plus >= len_eff;
  assign count_wide = 32'(count);

  // handshake and queue write
  assign in_ready = ~q_status.full;
  assign accept   = in_valid & in_ready;
  assign emit     = capturing | fire;
  assign q_push   = accept & emit;

  assign q_item.a     = in_a;
  assign q_item.b     = in_b;
  assign q_item.index = count_wide[setc_pkg::INDEX_W-1:0];
  assign q_item.last  = last;

  // capture control
  always_ff @(posedge clk) begin
    if (rst) begin
      capturing <= 1'b0;
      count     <= '0;
    end else if (accept) begin
      capturing <= emit & ~last;
      count     <= (emit & ~last) ? CNT_W'(count_plus) : '0;
    end
  end

  // history and previous smoothed value, frozen during a capture
  always_ff @(posedge clk) begin
    if (rst) begin
      hist[0] <= '0;
      hist[1] <= '0;
      hist[2] <= '0;
      hist[3] <= '0;
      prev_sm <= '0;
    end else if (accept && !capturing) begin
      hist[0] <= in_a;
      hist[1] <= hist[0];
      hist[2] <= hist[1];
      hist[3] <= hist[2];
      prev_sm <= smoothed;
    end
  end

endmodule

FILE: design/setc_fifo.sv
module setc_fifo (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  setc_pkg::item_t         push_item,
  input  logic                    pop,
  output setc_pkg::item_t         pop_item,
  output setc_pkg::queue_status_t status
);

  localparam int AW = setc_pkg::QUEUE_AW;
  localparam int CW = AW + 1;

  setc_pkg::item_t mem [setc_pkg::QUEUE_DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   fill;
  logic            do_push;
  logic            do_pop;

  assign status.full  = fill == CW'(setc_pkg::QUEUE_DEPTH);
  assign status.empty = fill == '0;
  assign do_push      = push & ~status.full;
  assign do_pop       = pop & ~status.empty;
  assign pop_item     = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + CW'(1);
        2'b01:   fill <= fill - CW'(1);
        default: ;
      endcase
    end
  end

endmodule

FILE: design/setc_back.sv
module setc_back (
  input  logic                    clk,
  input  logic                    rst,
  // queue read side
  input  setc_pkg::queue_status_t q_status,
  input  setc_pkg::item_t         q_item,
  output logic                    q_pop,
  // result output
  output logic                    out_valid,
  input  logic                    out_ready,
  output setc_pkg::item_t         out_item
);

  // load the output register whenever it is free or being drained
  assign q_pop = ~q_status.empty & (~out_valid | out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (~out_valid | out_ready) begin
      out_valid <= ~q_status.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_item <= q_item;
    end
  end

endmodule

FILE: design/scope_edge_trigger_capture_top.sv
// Oscilloscope edge trigger with 1-2-3-2-1 smoothing and capture engine. Each
// input item is a sample pair (trigger channel, second channel). While armed,
// the block fires when the trigger channel crosses the level register / 20 in
// the direction set by slope_select and the smoothed trace moves the same way;
// it then emits capture_length pairs (0 acts as 1, clamped to MAX_CAPTURE),
// starting with the triggering pair, with tlast on the final one, and
// re-arms. Items that are not captured produce no output. The block takes
// one item per clock cycle while s_tready is high: the whole trigger decision
// (weighted sum, divide by 9 via reciprocal multiply, compares) resolves
// combinationally in the front stage. Results pass through a 4-entry queue
// and an output register: an accepted item is written into the queue and
// then loaded into the output register, which raises m_tvalid. s_tready
// drops only when the queue is full under output backpressure. Write
// configuration only while no capture output is pending.
module scope_edge_trigger_capture_top #(
  parameter int MAX_CAPTURE = setc_pkg::MAX_CAPTURE_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration write port
  input  logic                       cfg_wen,
  input  logic [1:0]                 cfg_addr,
  input  logic [setc_pkg::CFG_W-1:0] cfg_wdata,
  // sample input
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [15:0]                s_tdata,   // [7:0] sample_a, [15:8] sample_b
  // captured output
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [31:0]                m_tdata,   // [7:0] captured_a, [15:8] captured_b,
                                                // [27:16] capture_index, [31:28] zero
  output logic                       m_tlast    // last_flag
);

  setc_pkg::queue_status_t q_status;
  setc_pkg::item_t         push_item;
  setc_pkg::item_t         pop_item;
  setc_pkg::item_t         out_item;
  logic                    q_push;
  logic                    q_pop;

  setc_front #(
    .MAX_CAPTURE(MAX_CAPTURE)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_a     (s_tdata[7:0]),
    .in_b     (s_tdata[15:8]),
    .q_status (q_status),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  setc_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_item(push_item),
    .pop      (q_pop),
    .pop_item (pop_item),
    .status   (q_status)
  );

  setc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .q_item   (pop_item),
    .q_pop    (q_pop),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_item (out_item)
  );

  // pack result fields
  assign m_tdata = {4'b0000, out_item.index, out_item.b, out_item.a};
  assign m_tlast = out_item.last;

endmodule
